@@ design/radial_stick_clamp_defines.svh @@
// Assertion macros for the radial stick clamp checker.
`ifndef RADIAL_STICK_CLAMP_DEFINES_SVH
`define RADIAL_STICK_CLAMP_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define RSC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define RSC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rsc_pkg.sv @@
// Shared types of the radial stick clamp.
`default_nettype none

package rsc_pkg;

  // Status that every serial arithmetic unit reports to the sequencer.
  typedef struct packed {
    logic busy;
  } rsc_stat_t;

endpackage

`default_nettype wire

@@ design/rsc_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none

module rsc_mul #(
  parameter int W = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [W-1:0]       a_i,
  input  wire logic [W-1:0]       b_i,
  output logic      [2*W-1:0]     prod_o,
  output rsc_pkg::rsc_stat_t      stat_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   a_q;
  logic [2*W-1:0] prod_q;
  logic [2*W-1:0] prod_d;
  logic [W:0]     sum;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;

  // Add the multiplicand into the upper half when the current bit is set, then shift.
  always_comb begin
    sum    = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, a_q} : {(W+1){1'b0}});
    prod_d = {sum, prod_q[W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{W{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o      = prod_q;
  assign stat_o.busy = busy_q;

endmodule

`default_nettype wire

@@ design/rsc_sqrt.sv @@
// Digit-serial ceiling square root, one base-4 digit of the radicand per cycle.
`default_nettype none

module rsc_sqrt #(
  parameter int W = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2*W-1:0]     v_i,
  output logic      [W-1:0]       root_o,
  output rsc_pkg::rsc_stat_t      stat_o
);

  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] v_q;
  logic [W:0]     rem_q;
  logic [W-1:0]   root_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic [W+1:0]   r4;
  logic [W+1:0]   trial;
  logic [W+1:0]   diff;
  logic           ge;

  // Bring down the next digit and try root*4+1 against the partial remainder.
  always_comb begin
    r4    = {rem_q[W-1:0], v_q[2*W-1:2*W-2]};
    trial = {root_q, 2'b01};
    ge    = (r4 >= trial);
    diff  = r4 - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= v_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      v_q    <= {v_q[2*W-3:0], 2'b00};
      rem_q  <= ge ? diff[W:0] : r4[W:0];
      root_q <= {root_q[W-2:0], ge};
    end
  end

  // Round the floor root up when anything is left over.
  assign root_o      = root_q + W'(rem_q != '0);
  assign stat_o.busy = busy_q;

endmodule

`default_nettype wire

@@ design/rsc_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module rsc_div #(
  parameter int W = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2*W-1:0]     num_i,
  input  wire logic [W-1:0]       den_i,
  output logic      [W-1:0]       quo_o,
  output rsc_pkg::rsc_stat_t      stat_o
);

  localparam int CW = $clog2(W + 1);

  // The upper half of the dividend is below the divisor, so the quotient fits W bits.
  logic [W-1:0]  rem_q;
  logic [W-1:0]  lo_q;
  logic [W-1:0]  den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [W:0]    t;
  logic [W:0]    diff;
  logic          ge;

  always_comb begin
    t    = {rem_q, lo_q[W-1]};
    ge   = (t >= {1'b0, den_q});
    diff = t - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Shift dividend bits out of the low register and quotient bits in behind them.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[2*W-1:W];
      lo_q  <= num_i[W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : t[W-1:0];
      lo_q  <= {lo_q[W-2:0], ge};
    end
  end

  assign quo_o       = lo_q;
  assign stat_o.busy = busy_q;

endmodule

`default_nettype wire

@@ design/radial_stick_clamp.sv @@
// Radial clamp of one analog-stick sample, top level.
//
// Each sample (in_x_i, in_y_i) is limited to a circle of radius cfg_radius_i. With a
// radius of zero, or with x*x + y*y not above radius*radius, the sample leaves unchanged.
// Otherwise the block takes d as the ceiling square root of x*x + y*y and returns
// x*radius/d and y*radius/d, each quotient truncated toward zero. All arithmetic is
// digit serial: three shift-add multipliers form x*x, y*y and radius*radius one bit a
// cycle, a base-4 root unit forms d one digit a cycle while two multipliers form
// |x|*radius and |y|*radius, and two restoring dividers produce one quotient bit a cycle.
// A sample that passes unchanged runs only the squaring pass and the compare, then
// goes to the output; a clamped sample runs the squaring pass, the compare, the root and
// scaled-product pass and the divide pass in that order. One sample is in work at
// a time; in_stall_o drops at the same edge that moves the result into the output
// register, so the next sample is taken while that result still waits to be drained.
// cfg_ready_o is always high; write the radius only while the block is idle.
`default_nettype none

module radial_stick_clamp #(
  parameter int AXIS_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write beat
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic        [AXIS_BITS-2:0] cfg_radius_i,
  // sample input
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic signed [AXIS_BITS-1:0] in_x_i,
  input  wire logic signed [AXIS_BITS-1:0] in_y_i,
  // clamped sample output
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed      [AXIS_BITS-1:0] out_x_o,
  output logic signed      [AXIS_BITS-1:0] out_y_o
);

  localparam int N = AXIS_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_CMP,
    ST_ROOT,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e state_q;

  logic [N-2:0]        radius_q;
  logic [N-1:0]        radius_ext;

  // sample held while it is in work
  logic signed [N-1:0] raw_x_q, raw_y_q;
  logic [N-1:0]        mag_x_q, mag_y_q;
  logic                neg_x_q, neg_y_q;

  // result waiting for the output register
  logic signed [N-1:0] res_x_q, res_y_q;

  logic                out_valid_q;
  logic signed [N-1:0] out_x_q, out_y_q;

  logic [N-1:0]        in_mag_x, in_mag_y;
  logic                in_accept;
  logic                sq_start, prod_start, div_start;
  logic                mul_start;
  logic [N-1:0]        mx_a, mx_b, my_a, my_b;
  logic [2*N-1:0]      prod_x, prod_y, prod_r;
  logic [2*N-1:0]      dist2;
  logic                clamp;
  logic [N-1:0]        root;
  logic [N-1:0]        quo_x, quo_y;
  logic [N-1:0]        scl_x, scl_y;
  logic                units_idle;
  logic                slot_free;

  rsc_pkg::rsc_stat_t  stat_mx, stat_my, stat_mr, stat_rt, stat_dx, stat_dy;

  // Configuration: one register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_radius_i;
    end
  end

  assign radius_ext = {1'b0, radius_q};

  // Magnitudes straight off the ports; the most negative code maps to 2^(N-1).
  assign in_mag_x = in_x_i[N-1] ? (~$unsigned(in_x_i) + N'(1)) : $unsigned(in_x_i);
  assign in_mag_y = in_y_i[N-1] ? (~$unsigned(in_y_i) + N'(1)) : $unsigned(in_y_i);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Compare squared length against squared radius once all three squares are in.
  assign dist2 = prod_x + prod_y;
  assign clamp = (radius_q != '0) && (dist2 > prod_r);

  assign units_idle = !stat_mx.busy && !stat_my.busy && !stat_mr.busy &&
                      !stat_rt.busy && !stat_dx.busy && !stat_dy.busy;

  // Start the squares on accept; start root and scaled products together after compare.
  assign sq_start   = in_accept;
  assign prod_start = (state_q == ST_CMP) && clamp;
  assign div_start  = (state_q == ST_ROOT) && units_idle;
  assign mul_start  = sq_start || prod_start;

  // Square the axis on accept, multiply it by the radius afterwards.
  assign mx_a = (state_q == ST_IDLE) ? in_mag_x : mag_x_q;
  assign mx_b = (state_q == ST_IDLE) ? in_mag_x : radius_ext;
  assign my_a = (state_q == ST_IDLE) ? in_mag_y : mag_y_q;
  assign my_b = (state_q == ST_IDLE) ? in_mag_y : radius_ext;

  rsc_mul #(.W(N)) u_mul_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mx_a),
    .b_i     (mx_b),
    .prod_o  (prod_x),
    .stat_o  (stat_mx)
  );

  rsc_mul #(.W(N)) u_mul_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (my_a),
    .b_i     (my_b),
    .prod_o  (prod_y),
    .stat_o  (stat_my)
  );

  rsc_mul #(.W(N)) u_mul_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .a_i     (radius_ext),
    .b_i     (radius_ext),
    .prod_o  (prod_r),
    .stat_o  (stat_mr)
  );

  rsc_sqrt #(.W(N)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prod_start),
    .v_i     (dist2),
    .root_o  (root),
    .stat_o  (stat_rt)
  );

  rsc_div #(.W(N)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_x),
    .den_i   (root),
    .quo_o   (quo_x),
    .stat_o  (stat_dx)
  );

  rsc_div #(.W(N)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_y),
    .den_i   (root),
    .quo_o   (quo_y),
    .stat_o  (stat_dy)
  );

  // Restore the sign on the truncated quotients.
  assign scl_x = neg_x_q ? (~quo_x + N'(1)) : quo_x;
  assign scl_y = neg_y_q ? (~quo_y + N'(1)) : quo_y;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      res_x_q     <= '0;
      res_y_q     <= '0;
      raw_x_q     <= '0;
      raw_y_q     <= '0;
      mag_x_q     <= '0;
      mag_y_q     <= '0;
      neg_x_q     <= 1'b0;
      neg_y_q     <= 1'b0;
    end else begin
      // Drop the output beat once it is taken, unless a new result replaces it.
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            raw_x_q <= in_x_i;
            raw_y_q <= in_y_i;
            mag_x_q <= in_mag_x;
            mag_y_q <= in_mag_y;
            neg_x_q <= in_x_i[N-1];
            neg_y_q <= in_y_i[N-1];
            state_q <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (units_idle) begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (clamp) begin
            state_q <= ST_ROOT;
          end else begin
            res_x_q <= raw_x_q;
            res_y_q <= raw_y_q;
            state_q <= ST_EMIT;
          end
        end
        ST_ROOT: begin
          if (units_idle) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (units_idle) begin
            res_x_q <= $signed(scl_x);
            res_y_q <= $signed(scl_y);
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Hold the result until the output register is free.
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_x_q;
            out_y_q     <= res_y_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;

endmodule

`default_nettype wire

@@ design/rsc_checker.sv @@
// Port-level checker for the radial stick clamp, bound to the top level.
`default_nettype none
`include "radial_stick_clamp_defines.svh"

module rsc_checker #(
  parameter int AXIS_BITS = 16
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic signed [AXIS_BITS-1:0] out_x_o,
  input wire logic signed [AXIS_BITS-1:0] out_y_o
);

  // Hold the output beat and its payload while stalled.
  `RSC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output beat dropped")
  `RSC_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_x_o) && $stable(out_y_o), "stalled payload changed")

  // One sample in work at a time: stall right after every accepted beat.
  `RSC_ASSERT_NEXT(a_one_in_work, in_valid_i && !in_stall_o, in_stall_o, "second sample taken while busy")

  // A result never shows up in the cycle right after its sample was taken.
  `RSC_ASSERT_NEXT(a_no_early_out, in_valid_i && !in_stall_o, !$rose(out_valid_o), "result appeared too early")

endmodule

bind radial_stick_clamp rsc_checker #(.AXIS_BITS(AXIS_BITS)) u_rsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o)
);

`default_nettype wire

@@ verif/tb_radial_stick_clamp.sv @@
// Self-checking testbench for the radial stick clamp, with directed, back-pressure and random tests.
`timescale 1ns / 100ps

module tb_radial_stick_clamp;

  localparam int AXIS = 16;
  // Settle time after the last result, kept above the slowest sample's run from accept to result.
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int GAP_MAX = 18;

  typedef struct packed {
    logic signed [AXIS-1:0] x;
    logic signed [AXIS-1:0] y;
  } stick_t;

  logic clk_i;
  logic rst_ni;

  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [AXIS-2:0]        cfg_radius_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic signed [AXIS-1:0] in_x_i;
  logic signed [AXIS-1:0] in_y_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic signed [AXIS-1:0] out_x_o;
  logic signed [AXIS-1:0] out_y_o;

  // Output stall is the per-beat random stall or the long hold-off, both driven at the edge.
  logic rx_stall;
  logic hold_active;
  assign out_stall_i = rx_stall | hold_active;

  // Testbench copy of the radius register and the store of clamped samples still owed.
  logic [AXIS-2:0] radius_now;
  stick_t          clamped_q[$];

  // Idle pattern controls: when set, that side never inserts gaps.
  bit tx_burst;
  bit rx_burst;

  int errors;
  int n_samples;
  int n_clamped;
  int n_results;
  int n_radius_writes;

  radial_stick_clamp #(
    .AXIS_BITS(AXIS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_radius_i(cfg_radius_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run-away guard: far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Clamp one sample to the circle; flag whether the clamp acted.
  function automatic stick_t predict_clamp(input logic [AXIS-2:0] r, input stick_t s,
                                           output bit acted);
    logic [63:0] mag_x;
    logic [63:0] mag_y;
    logic [63:0] len2;
    logic [63:0] r64;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] qx;
    logic [63:0] qy;
    stick_t      res;
    mag_x = {48'd0, s.x[AXIS-1] ? AXIS'(-s.x) : AXIS'(s.x)};
    mag_y = {48'd0, s.y[AXIS-1] ? AXIS'(-s.y) : AXIS'(s.y)};
    len2  = mag_x * mag_x + mag_y * mag_y;
    r64   = {49'd0, r};
    acted = 1'b0;
    if (r64 == 0 || len2 <= r64 * r64) begin
      return s;
    end
    acted = 1'b1;
    // Floor root bit by bit, then round up to the ceiling.
    root = '0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= len2) root = trial;
    end
    if (root * root < len2) root = root + 1;
    qx = (mag_x * r64) / root;
    qy = (mag_y * r64) / root;
    res.x = s.x[AXIS-1] ? AXIS'(-qx) : AXIS'(qx);
    res.y = s.y[AXIS-1] ? AXIS'(-qy) : AXIS'(qy);
    return res;
  endfunction

  // Offer one sample after a random gap; record the clamped value once the beat is taken.
  task automatic send_sample(input logic signed [AXIS-1:0] x, input logic signed [AXIS-1:0] y);
    int     gap;
    stick_t s;
    bit     acted;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_x_i     <= x;
    in_y_i     <= y;
    do @(posedge clk_i); while (in_stall_o);
    s.x = x;
    s.y = y;
    clamped_q.push_back(predict_clamp(radius_now, s, acted));
    n_samples++;
    if (acted) n_clamped++;
  endtask

  task automatic end_offer();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every owed result is back, then let the datapath settle.
  task automatic wait_drained();
    while (clamped_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [AXIS-2:0] r);
    cfg_valid_i  <= 1'b1;
    cfg_radius_i <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    radius_now = r;
    n_radius_writes++;
    @(posedge clk_i);
  endtask

  // Axis value biased toward the circle edge, the field extremes and small deflections.
  function automatic logic signed [AXIS-1:0] rand_axis(input logic [AXIS-2:0] r);
    int unsigned sel;
    int          lim;
    int          v;
    sel = $urandom_range(0, 99);
    if (sel < 40) return AXIS'($urandom);
    if (sel < 70) begin
      lim = (r == 0) ? 64 : int'(r) + int'(r) / 4 + 2;
      if (lim > 32767) lim = 32767;
      v = int'($urandom_range(0, 2 * lim)) - lim;
      return AXIS'(v);
    end
    if (sel < 85) begin
      case ($urandom_range(0, 3))
        0: return -16'sd32768;
        1: return 16'sd32767;
        2: return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    v = int'($urandom_range(0, 16)) - 8;
    return AXIS'(v);
  endfunction

  // Receiver: draw a stall length per beat, then take the next result.
  initial begin : receiver
    int gap;
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        rx_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      rx_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Compare every result beat against the oldest owed sample.
  always @(posedge clk_i) begin : result_check
    stick_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (clamped_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual x=%0d y=%0d",
                 $time, out_x_o, out_y_o);
      end else begin
        want = clamped_q.pop_front();
        if (out_x_o !== want.x) begin
          errors++;
          $display("%0t out_x mismatch: expected %0d, actual %0d", $time, want.x, out_x_o);
        end
        if (out_y_o !== want.y) begin
          errors++;
          $display("%0t out_y mismatch: expected %0d, actual %0d", $time, want.y, out_y_o);
        end
      end
    end
  end

  // Radius resets to zero: everything, extremes included, must pass through.
  task automatic test_reset_passthrough();
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd1, -16'sd1);
    end_offer();
    wait_drained();
  endtask

  // Samples inside or exactly on the circle leave unchanged.
  task automatic test_inside_circle();
    write_radius(15'd1000);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd1000, 16'sd0);
    send_sample(16'sd0, -16'sd1000);
    send_sample(16'sd600, -16'sd800);
    send_sample(-16'sd707, 16'sd707);
    end_offer();
    wait_drained();
  endtask

  // Samples just outside the circle, full-scale negatives and the radius extremes.
  task automatic test_clamp_edges();
    send_sample(16'sd1001, 16'sd0);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd3, 16'sd1000);
    end_offer();
    wait_drained();
    write_radius(15'h7fff);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(16'sd32767, 16'sd0);
    end_offer();
    wait_drained();
    // Smallest radius: quotients collapse to one or to zero.
    write_radius(15'd1);
    send_sample(16'sd2, 16'sd0);
    send_sample(-16'sd1, -16'sd1);
    send_sample(16'sd1, 16'sd0);
    send_sample(-16'sd32768, 16'sd5);
    end_offer();
    wait_drained();
  endtask

  // Hold the output off for a long stretch while samples keep coming, so input stalls.
  task automatic test_backpressure();
    write_radius(15'd12000);
    tx_burst = 1'b1;
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_active <= 1'b0;
      end
      begin
        for (int i = 0; i < 8; i++) send_sample(rand_axis(radius_now), rand_axis(radius_now));
        end_offer();
      end
    join
    tx_burst = 1'b0;
    wait_drained();
  endtask

  // Random samples across several radius settings and idle patterns.
  task automatic test_random_sweep();
    logic [AXIS-2:0] radii[7];
    radii[0] = 15'd0;
    radii[1] = 15'h7fff;
    radii[2] = 15'd1;
    radii[3] = (AXIS-1)'($urandom_range(1, 32766));
    radii[4] = (AXIS-1)'($urandom_range(1, 32766));
    radii[5] = (AXIS-1)'($urandom_range(2, 300));
    radii[6] = (AXIS-1)'($urandom_range(16000, 32766));
    foreach (radii[p]) begin
      write_radius(radii[p]);
      for (int i = 0; i < 215; i++) begin
        // Re-draw the idle pattern every few dozen beats.
        if (i % 40 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        send_sample(rand_axis(radius_now), rand_axis(radius_now));
      end
      end_offer();
      tx_burst = 1'b0;
      rx_burst = 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    errors          = 0;
    n_samples       = 0;
    n_clamped       = 0;
    n_results       = 0;
    n_radius_writes = 0;
    radius_now      = '0;
    tx_burst        = 1'b0;
    rx_burst        = 1'b0;
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_radius_i <= '0;
    in_valid_i   <= 1'b0;
    in_x_i       <= '0;
    in_y_i       <= '0;
    hold_active  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_passthrough();
    test_inside_circle();
    test_clamp_edges();
    test_backpressure();
    test_random_sweep();

    wait_drained();
    $display("covered %0d samples (%0d clamped), %0d results checked, %0d radius writes",
             n_samples, n_clamped, n_results, n_radius_writes);
    $display("with random gaps on both sides and one long output hold-off; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
